// ===== hw/rtl/qbr_pkg.sv =====
// qbr_pkg: shared widths, codes and reset values for the quadratic bisection root unit
// no dependencies; imported by the channel interfaces and the top level

package qbr_pkg;

   // default module parameters
   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   // fixed field widths
   localparam int TOL_W      = 31;
   localparam int MAXDIV_W   = 6;
   localparam int ROOT_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = TOL_W;
   localparam int CSR_IDX_W  = 1;
   // signed compare width for interval width against tolerance
   localparam int CMP_W      = TOL_W + 2;

   // register reset values
   localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(66);
   localparam logic [MAXDIV_W-1:0] MAXDIV_RESET = MAXDIV_W'(32);

   // polynomial f(x) = x*x - POLY_LIN*x + POLY_CONST
   localparam int POLY_LIN   = 6;
   localparam int POLY_CONST = 2;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOLERANCE = 1'b0,
      CSR_MAX_DIV   = 1'b1
   } csr_index_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_MIDPOINT = 2'd0,
      STATUS_EXACT    = 2'd1,
      STATUS_NO_ROOT  = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/qbr_req_if.sv =====
// qbr_req_if: request channel carrying one search interval
// depends on qbr_pkg

interface qbr_req_if #(
   parameter int VALUE_WIDTH = qbr_pkg::DEF_VALUE_WIDTH
);
   import qbr_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] lower_bound;
   logic signed [VALUE_WIDTH-1:0] upper_bound;

   modport source (output valid, output lower_bound, output upper_bound, input ready);
   modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

// ===== hw/rtl/qbr_rsp_if.sv =====
// qbr_rsp_if: response channel carrying one root estimate
// depends on qbr_pkg

interface qbr_rsp_if;
   import qbr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [ROOT_W-1:0]   root_value;
   status_type                 status;
   logic        [MAXDIV_W-1:0] divisions_used;

   modport source (output valid, output root_value, output status, output divisions_used,
                   input ready);
   modport sink   (input valid, input root_value, input status, input divisions_used,
                   output ready);
endinterface

// ===== hw/rtl/quadratic_bisection_root_unit.sv =====
// quadratic_bisection_root_unit: bisection root finder for f(x) = x*x - 6x + 2
// depends on qbr_pkg, qbr_req_if and qbr_rsp_if
//
// usage
//  - req_chan transfers one interval [lower_bound, upper_bound] in signed fixed point
//    with FRAC_BITS fraction bits; rsp_chan transfers exactly one result for it
//  - csr_* is a plain write port: index 0 tolerance, index 1 max_divisions; write only
//    while the unit is idle
//  - req_chan.ready is high only while the sequencer is idle; one interval at a time
//  - every evaluation of f goes through one shared signed multiplier (x*x, registered)
//    and one wide add and sign test, in a multiply state followed by a sign state
//  - order of work: the two end evaluations, then per halving a width check, a multiply
//    and a sign step, then a final width check and the output step; at most
//    max_divisions halvings, so up to 63, or 32 at the reset value
//  - the result sits in an output register; a new interval is taken while it waits,
//    and a finished search holds in its done state until rsp_chan is free
//  - reset (synchronous, active high) returns to idle, drops rsp_chan.valid and loads
//    tolerance 66 and max_divisions 32

module quadratic_bisection_root_unit #(
   parameter int FRAC_BITS   = qbr_pkg::DEF_FRAC_BITS,
   parameter int VALUE_WIDTH = qbr_pkg::DEF_VALUE_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   qbr_req_if.sink                            req_chan,
   qbr_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [qbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qbr_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import qbr_pkg::*;

   localparam int VW = VALUE_WIDTH;
   // widths of the three terms of f scaled by 2^(2*FRAC_BITS)
   localparam int T_SQ  = 2 * VW;
   localparam int T_LIN = VW + 3 + FRAC_BITS;
   localparam int T_CST = 2 * FRAC_BITS + 2;
   localparam int T_MAX = (T_SQ > T_LIN) ? ((T_SQ > T_CST) ? T_SQ : T_CST)
                                         : ((T_LIN > T_CST) ? T_LIN : T_CST);
   localparam int R_W   = T_MAX + 2;
   localparam logic signed [R_W-1:0] CST_TERM =
      R_W'(POLY_CONST) <<< (2 * FRAC_BITS);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_SGN   = 5'b00100,
      S_CHECK = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // which point the shared unit is evaluating
   typedef enum logic [2:0] {
      PH_LO  = 3'b001,
      PH_HI  = 3'b010,
      PH_MID = 3'b100
   } phase_type;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [TOL_W-1:0]         tol_ff, tol_in;
   logic [MAXDIV_W-1:0]      maxdiv_ff, maxdiv_in;
   logic [MAXDIV_W-1:0]      count_ff, count_in;
   logic signed [VW-1:0]     lo_ff, lo_in;
   logic signed [VW-1:0]     hi_ff, hi_in;
   logic signed [VW-1:0]     x_ff, x_in;
   logic signed [T_SQ-1:0]   sq_ff, sq_in;
   logic                     lo_neg_ff, lo_neg_in;
   logic [VW-1:0]            res_root_ff, res_root_in;
   status_type               res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]        rsp_root_ff, rsp_root_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [MAXDIV_W-1:0]      rsp_div_ff, rsp_div_in;

   logic                     req_transfer;
   logic                     rsp_free;
   logic signed [R_W-1:0]    x_ext;
   logic signed [R_W-1:0]    lin_term;
   logic signed [R_W-1:0]    poly;
   logic                     poly_neg;
   logic                     poly_zero;
   logic signed [VW:0]       pair_sum;
   logic signed [VW:0]       span;
   logic signed [VW-1:0]     mid;
   logic                     keep_going;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign req_transfer          = req_chan.valid && req_chan.ready;
   assign rsp_free              = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.root_value     = rsp_root_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.divisions_used = rsp_div_ff;

   // sign of f from the registered square
   always_comb begin
      x_ext     = R_W'(x_ff);
      lin_term  = ((x_ext <<< 2) + (x_ext <<< 1)) <<< FRAC_BITS;
      poly      = R_W'(sq_ff) - lin_term + CST_TERM;
      poly_neg  = poly[R_W-1];
      poly_zero = (poly == '0);
   end

   // midpoint rounded toward minus infinity, and interval width test
   always_comb begin
      pair_sum   = (VW+1)'(lo_ff) + (VW+1)'(hi_ff);
      mid        = pair_sum[VW:1];
      span       = (VW+1)'(hi_ff) - (VW+1)'(lo_ff);
      keep_going = ($signed(CMP_W'(span)) > $signed({2'b00, tol_ff}))
                   && (count_ff < maxdiv_ff);
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      x_in          = x_ff;
      sq_in         = sq_ff;
      lo_neg_in     = lo_neg_ff;
      res_root_in   = res_root_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_root_in   = rsp_root_ff;
      rsp_status_in = rsp_status_ff;
      rsp_div_in    = rsp_div_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_transfer) begin
               lo_in    = req_chan.lower_bound;
               hi_in    = req_chan.upper_bound;
               x_in     = req_chan.lower_bound;
               phase_in = PH_LO;
               count_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            sq_in    = x_ff * x_ff;
            state_in = S_SGN;
         end
         S_SGN: begin
            unique case (phase_ff)
               PH_LO: begin
                  lo_neg_in = poly_neg;
                  if (poly_zero) begin
                     res_root_in   = lo_ff;
                     res_status_in = STATUS_EXACT;
                     state_in      = S_DONE;
                  end else begin
                     x_in     = hi_ff;
                     phase_in = PH_HI;
                     state_in = S_MUL;
                  end
               end
               PH_HI: begin
                  if (poly_zero) begin
                     res_root_in   = hi_ff;
                     res_status_in = STATUS_EXACT;
                     state_in      = S_DONE;
                  end else if (poly_neg == lo_neg_ff) begin
                     res_root_in   = '0;
                     res_status_in = STATUS_NO_ROOT;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_CHECK;
                  end
               end
               PH_MID: begin
                  if (poly_zero) begin
                     res_root_in   = x_ff;
                     res_status_in = STATUS_EXACT;
                     state_in      = S_DONE;
                  end else begin
                     // keep the left half when it holds the sign change
                     if (poly_neg != lo_neg_ff) begin
                        hi_in = x_ff;
                     end else begin
                        lo_in = x_ff;
                     end
                     state_in = S_CHECK;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_CHECK: begin
            if (keep_going) begin
               count_in = count_ff + MAXDIV_W'(1);
               x_in     = mid;
               phase_in = PH_MID;
               state_in = S_MUL;
            end else begin
               res_root_in   = mid;
               res_status_in = STATUS_MIDPOINT;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_root_in   = ROOT_W'(res_root_ff);
               rsp_status_in = res_status_ff;
               rsp_div_in    = (res_status_ff == STATUS_NO_ROOT) ? '0 : count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      tol_in    = tol_ff;
      maxdiv_in = maxdiv_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TOLERANCE: tol_in    = csr_write_data;
            CSR_MAX_DIV:   maxdiv_in = csr_write_data[MAXDIV_W-1:0];
            default:       tol_in    = tol_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LO;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= TOL_RESET;
         maxdiv_ff    <= MAXDIV_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff       <= tol_in;
         maxdiv_ff    <= maxdiv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      x_ff          <= x_in;
      sq_ff         <= sq_in;
      lo_neg_ff     <= lo_neg_in;
      res_root_ff   <= res_root_in;
      res_status_ff <= res_status_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_status_ff <= rsp_status_in;
      rsp_div_ff    <= rsp_div_in;
   end

`ifndef ASSERT_OFF
   // an accepted interval starts with the lower end on the multiplier
   a_start_lo: assert property (@(posedge clock) disable iff (reset)
      req_transfer |=> (state_ff == S_MUL) && (phase_ff == PH_LO))
      else $error("accepted interval did not start the lower end evaluation");

   // every multiply is followed by its sign step
   a_mul_sgn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |=> (state_ff == S_SGN))
      else $error("multiply not followed by sign step");

   // a result only appears out of the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done state");

   // halvings are counted only by the width check
   a_count_src: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff == S_CHECK) || $past(req_transfer)))
      else $error("division count changed outside the width check");

   // no sign change gives a zero root and no halvings
   a_no_root: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_NO_ROOT))
      |-> ((rsp_root_ff == '0) && (rsp_div_ff == '0)))
      else $error("no-root result carries a value");
`endif

endmodule

// ===== tb/tb_quadratic_bisection_root_unit.sv =====
`timescale 1ns / 1ps
// tb_quadratic_bisection_root_unit: self-checking bench for the bisection root unit
// depends on qbr_pkg, qbr_req_if, qbr_rsp_if and quadratic_bisection_root_unit

module tb_quadratic_bisection_root_unit;
   import qbr_pkg::*;

   localparam int FRAC_BITS      = 16;
   localparam int VALUE_WIDTH    = 32;
   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_PHASES  = 6;
   localparam int ITEMS_PER_PHASE = 108;
   // receiver hold-off long enough to back the unit up into its input
   localparam int HOLD_CYCLES    = 300;
   // allow the longest search, hold-off, stalls and gaps several times over
   localparam int QUIET_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 200;

   // f(x) = x*x - 6x + 2
   localparam longint POLY_LINEAR   = 6;
   localparam longint POLY_CONSTANT = 2;

   localparam longint MIN_Q = -64'sd2147483648;
   localparam longint MAX_Q = 64'sd2147483647;
   // grid points on either side of the two roots (3 -/+ sqrt 7); f is never exactly
   // zero on the Q16.16 grid, so exact-root results cannot occur at this precision
   localparam longint LOW_ROOT_BELOW  = 23216;
   localparam longint LOW_ROOT_ABOVE  = 23217;
   localparam longint HIGH_ROOT_BELOW = 369999;
   localparam longint HIGH_ROOT_ABOVE = 370000;
   localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;

   localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};

   typedef struct packed {
      logic signed [ROOT_W-1:0] root;
      status_type               status;
      logic [MAXDIV_W-1:0]      divisions;
   } search_result_type;

   // expected-result store with its own copy of the search settings
   class root_scoreboard;
      logic [TOL_W-1:0]    tolerance;
      logic [MAXDIV_W-1:0] max_div;
      search_result_type   expected_q[$];
      int unsigned         errors;
      int unsigned         checked;
      int unsigned         status_seen[3];
      int unsigned         deepest;

      function new();
         tolerance = TOL_RESET;
         max_div   = MAXDIV_RESET;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TOLERANCE: tolerance = data[TOL_W-1:0];
            CSR_MAX_DIV:   max_div   = data[MAXDIV_W-1:0];
            default: ;
         endcase
      endfunction

      // sign of f(x) scaled by 2^(2*FRAC_BITS)
      function int poly_sign(longint x);
         longint r;
         r = x * x - (x * POLY_LINEAR) * ONE_Q + POLY_CONSTANT * ONE_Q * ONE_Q;
         if (r > 0) return 1;
         if (r < 0) return -1;
         return 0;
      endfunction

      function search_result_type bisect(longint lo, longint hi);
         search_result_type res;
         longint mid;
         int s_lo, s_hi, s_mid, count;
         bit done;
         res.root   = '0;
         res.status = STATUS_NO_ROOT;
         count = 0;
         s_lo = poly_sign(lo);
         s_hi = poly_sign(hi);
         if (s_lo == 0) begin
            res.root   = lo[ROOT_W-1:0];
            res.status = STATUS_EXACT;
         end else if (s_hi == 0) begin
            res.root   = hi[ROOT_W-1:0];
            res.status = STATUS_EXACT;
         end else if (s_lo != s_hi) begin
            done = 1'b0;
            while (!done) begin
               mid = (lo + hi) >>> 1;
               if ((hi - lo) > longint'(tolerance) && count < max_div) begin
                  count++;
                  s_mid = poly_sign(mid);
                  if (s_mid == 0) begin
                     res.root   = mid[ROOT_W-1:0];
                     res.status = STATUS_EXACT;
                     done = 1'b1;
                  end else if (s_mid != s_lo) begin
                     hi = mid;
                  end else begin
                     lo = mid;
                  end
               end else begin
                  res.root   = mid[ROOT_W-1:0];
                  res.status = STATUS_MIDPOINT;
                  done = 1'b1;
               end
            end
         end
         res.divisions = count[MAXDIV_W-1:0];
         return res;
      endfunction

      function void note_interval(logic signed [VALUE_WIDTH-1:0] lower,
                                  logic signed [VALUE_WIDTH-1:0] upper);
         expected_q.push_back(bisect(longint'(lower), longint'(upper)));
      endfunction

      function void check_result(logic signed [ROOT_W-1:0] root, status_type st,
                                 logic [MAXDIV_W-1:0] divs);
         search_result_type exp;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, got root %0d status %0d divisions %0d",
                     $time, root, st, divs);
            return;
         end
         exp = expected_q.pop_front();
         checked++;
         if (root !== exp.root) begin
            errors++;
            $display("%0t: root_value mismatch, expected %0d, got %0d",
                     $time, exp.root, root);
         end
         if (st !== exp.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, exp.status, st);
         end
         if (divs !== exp.divisions) begin
            errors++;
            $display("%0t: divisions_used mismatch, expected %0d, got %0d",
                     $time, exp.divisions, divs);
         end
         status_seen[int'(exp.status)]++;
         if (exp.divisions > deepest) deepest = exp.divisions;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   qbr_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_chan ();
   qbr_rsp_if                              rsp_chan ();

   root_scoreboard board = new();

   // per-phase idling style, and the one-shot receiver hold-off request
   bit req_no_gaps;
   bit rsp_no_stalls;
   bit hold_request;
   int settings_used;
   int unsigned quiet_cycles;

   quadratic_bisection_root_unit #(
      .FRAC_BITS   (FRAC_BITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // both channels are observed at the rising edge; the model sees each accepted interval
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_interval(req_chan.lower_bound, req_chan.upper_bound);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_result(rsp_chan.root_value, rsp_chan.status, rsp_chan.divisions_used);
   end

   // watchdog: any transfer or register write restarts the count
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_write_enable) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, board.pending());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver: random stalls, mostly short; a hold-off request blocks it for a long stretch
   initial begin : receiver
      int stall_left;
      int pick;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (rsp_no_stalls) begin
            rsp_chan.ready = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               rsp_chan.ready = 1'b1;
            end else begin
               stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
               rsp_chan.ready = 1'b0;
            end
         end
      end
   end

   function automatic int sender_gap_length();
      int pick;
      if (req_no_gaps) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // random magnitude in [0, limit] with a spread of scales
   function automatic longint random_span(longint limit);
      longint v;
      int scale;
      scale = $urandom_range(0, 32);
      v = longint'({$urandom(), $urandom()}) & ((64'sd1 <<< scale) - 1);
      if (v > limit) v = v % (limit + 1);
      return v;
   endfunction

   function automatic logic [TOL_W-1:0] random_tolerance();
      int scale;
      scale = $urandom_range(0, TOL_W);
      return TOL_W'($urandom() & ((64'd1 << scale) - 1));
   endfunction

   // mostly intervals that bracket one root, some reversed, the rest arbitrary
   task automatic random_interval(output logic signed [VALUE_WIDTH-1:0] lower,
                                  output logic signed [VALUE_WIDTH-1:0] upper);
      longint lo, hi, swap;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         if ($urandom_range(0, 1)) begin
            lo = LOW_ROOT_BELOW - random_span(LOW_ROOT_BELOW - MIN_Q);
            hi = LOW_ROOT_ABOVE + random_span(HIGH_ROOT_BELOW - LOW_ROOT_ABOVE);
         end else begin
            lo = LOW_ROOT_ABOVE + random_span(HIGH_ROOT_BELOW - LOW_ROOT_ABOVE);
            hi = HIGH_ROOT_ABOVE + random_span(MAX_Q - HIGH_ROOT_ABOVE);
         end
         if (pick >= 72) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
      end else begin
         lo = longint'($signed($urandom()));
         hi = longint'($signed($urandom()));
      end
      lower = lo[VALUE_WIDTH-1:0];
      upper = hi[VALUE_WIDTH-1:0];
   endtask

   // holds valid high until the transfer; valid stays up for a back-to-back item
   task automatic offer_interval(input longint lo, input longint hi);
      int gap;
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.lower_bound = lo[VALUE_WIDTH-1:0];
      req_chan.upper_bound = hi[VALUE_WIDTH-1:0];
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      gap = sender_gap_length();
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      board.set_register(idx, data);
   endtask

   // drop valid, let every search finish, then load new settings on an idle unit
   task automatic settle_and_configure(input logic [TOL_W-1:0] tol,
                                       input logic [MAXDIV_W-1:0] max_div);
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      write_register(CSR_TOLERANCE, CSR_DATA_W'(tol));
      write_register(CSR_MAX_DIV, CSR_DATA_W'(max_div));
      settings_used++;
   endtask

   initial begin : stimulus
      logic signed [VALUE_WIDTH-1:0] lower, upper;
      logic [TOL_W-1:0]    tol;
      logic [MAXDIV_W-1:0] max_div;
      int phase, i;

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.lower_bound = '0;
      req_chan.upper_bound = '0;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_TOLERANCE;
      csr_write_data       = '0;
      req_no_gaps          = 1'b0;
      rsp_no_stalls        = 1'b0;
      hold_request         = 1'b0;
      settings_used        = 1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed searches at the reset settings
      offer_interval(0, ONE_Q);                       // sign change across the low root
      offer_interval(3 * ONE_Q, 6 * ONE_Q);           // sign change across the high root
      offer_interval(ONE_Q, 0);                       // reversed interval, sign change
      offer_interval(ONE_Q, 5 * ONE_Q);               // both ends negative
      offer_interval(-10 * ONE_Q, -5 * ONE_Q);        // both ends positive
      offer_interval(MIN_Q, MAX_Q);                   // full range, no sign change
      offer_interval(MAX_Q, MIN_Q);                   // full range reversed
      offer_interval(MIN_Q, ONE_Q);                   // low root bracket from the bottom of the range
      offer_interval(ONE_Q, MAX_Q);                   // high root bracket up to the top of the range
      offer_interval(MIN_Q, 0);
      offer_interval(0, MAX_Q);
      offer_interval(0, 0);                           // degenerate interval
      offer_interval(-1, 0);
      offer_interval(LOW_ROOT_BELOW, LOW_ROOT_ABOVE); // one-ulp brackets
      offer_interval(HIGH_ROOT_BELOW, HIGH_ROOT_ABOVE);
      offer_interval(LOW_ROOT_ABOVE, LOW_ROOT_BELOW);
      // no halving allowed: the input midpoint comes straight back
      settle_and_configure(TOL_RESET, '0);
      offer_interval(0, ONE_Q);
      offer_interval(ONE_Q, 6 * ONE_Q);
      offer_interval(ONE_Q, 0);
      // zero tolerance, most halvings: every search runs to the division limit
      settle_and_configure('0, '1);
      offer_interval(0, ONE_Q);
      offer_interval(MIN_Q, ONE_Q);
      offer_interval(HIGH_ROOT_BELOW, HIGH_ROOT_ABOVE);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin tol = '0;       max_div = '1; end
            1: begin tol = TOL_MAX;  max_div = '1; end
            2: begin tol = random_tolerance(); max_div = '0; end
            4: begin tol = random_tolerance(); max_div = MAXDIV_RESET; end
            default: begin
               tol     = random_tolerance();
               max_div = MAXDIV_W'($urandom_range(0, 63));
            end
         endcase
         // phase 3: sender never idles and the receiver blocks once for a long stretch
         // phase 4: neither side idles
         req_no_gaps   = (phase == 3 || phase == 4);
         rsp_no_stalls = (phase == 4);
         settle_and_configure(tol, max_div);
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (phase == 3 && i == 10) hold_request = 1'b1;
            random_interval(lower, upper);
            offer_interval(longint'(lower), longint'(upper));
         end
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d searches checked under %0d register settings",
               board.checked, settings_used);
      $display("summary: %0d midpoint, %0d exact, %0d no sign change, deepest %0d halvings",
               board.status_seen[0], board.status_seen[1], board.status_seen[2],
               board.deepest);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
